// File: src/fts_pkg.sv
// Shared types and constants of the frame time statistics unit.
`default_nettype none
package fts_pkg;

    // input opcodes
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_SCENE_RST = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_DELTA  = 2'd0;
    localparam logic [1:0] CFG_TIME_SCALE = 2'd1;
    localparam logic [1:0] CFG_FPS_WINDOW = 2'd2;

    localparam logic [23:0] MAX_DELTA_RST  = 24'd100000;
    localparam logic [15:0] TIME_SCALE_RST = 16'd256;
    localparam logic [23:0] FPS_WINDOW_RST = 24'd1000000;

    localparam logic [27:0] FPS_SCALE = 28'd256000000;
    localparam logic [27:0] FPS_SAT   = 28'hFFFFFFF;
    localparam logic [23:0] CNT24_MAX = 24'hFFFFFF;

    // divider: remainder and divisor width, quotient width, bits per cycle
    localparam int DIV_REM_W  = 25;
    localparam int DIV_Q_W    = 32;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = DIV_Q_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // delta ring length, a power of two so the mean is a shift
    localparam int RING_DEPTH = 16;
    localparam int RING_LG    = $clog2(RING_DEPTH);

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        is_tick;
        logic [23:0] raw;
        logic [23:0] clamped;
        logic [31:0] scaled;
    } t_cmd;

    typedef struct packed {
        logic [DIV_REM_W-1:0] num_hi;
        logic [DIV_Q_W-1:0]   num_lo;
        logic [DIV_REM_W-1:0] divisor;
    } t_div_req;

endpackage
`default_nettype wire

// File: src/fts_front.sv
// Front end: takes input words, classifies them, clamps and scales ticks.
`default_nettype none
module fts_front
    import fts_pkg::*;
(
    input  wire logic        i_valid,
    input  wire logic        i_opcode,
    input  wire logic [23:0] i_raw_delta_us,
    input  wire logic [23:0] i_max_delta_us,
    input  wire logic [15:0] i_time_scale,
    input  wire logic        i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [23:0] w_clamped;
    logic [39:0] w_product;

    assign w_clamped = (i_raw_delta_us < i_max_delta_us) ? i_raw_delta_us : i_max_delta_us;
    assign w_product = 40'(w_clamped) * 40'(i_time_scale);

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd.is_tick = (i_opcode == OP_TICK);
        o_cmd.raw     = i_raw_delta_us;
        o_cmd.clamped = w_clamped;
        o_cmd.scaled  = w_product[39:8];
    end

endmodule
`default_nettype wire

// File: src/fts_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module fts_queue
    import fts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: src/fts_div.sv
// Radix-4 restoring divider: two quotient bits a cycle, high numerator part below divisor.
`default_nettype none
module fts_div
    import fts_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_div_req         i_req,
    output logic                  o_done,
    output logic [DIV_Q_W-1:0]    o_quot
);

    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_lo;
    logic [DIV_REM_W-1:0] r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_REM_W-1:0] n_rem;
    logic [DIV_Q_W-1:0]   n_lo;

    always_comb begin
        logic [DIV_REM_W:0]   v_sh;
        logic [DIV_REM_W-1:0] v_rem;
        logic [DIV_Q_W-1:0]   v_lo;
        logic                 v_ge;
        v_rem = r_rem;
        v_lo  = r_lo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            v_sh  = {v_rem, v_lo[DIV_Q_W-1]};
            v_ge  = (v_sh >= {1'b0, r_div});
            v_rem = v_ge ? DIV_REM_W'(v_sh - {1'b0, r_div}) : DIV_REM_W'(v_sh);
            v_lo  = {v_lo[DIV_Q_W-2:0], v_ge};
        end
        n_rem = v_rem;
        n_lo  = v_lo;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_req.num_hi;
            r_lo  <= i_req.num_lo;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule
`default_nettype wire

// File: src/fts_back.sv
// Back end: accumulators, delta ring, moving average and FPS window.
`default_nettype none
module fts_back
    import fts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_empty,
    input  wire t_cmd        i_cmd,
    output logic             o_pop,
    input  wire logic [23:0] i_fps_window_us,
    input  wire logic        i_stall,
    output logic             o_valid,
    output logic [23:0]      o_unscaled_delta_us,
    output logic [31:0]      o_scaled_delta_us,
    output logic [47:0]      o_game_time_us,
    output logic [47:0]      o_scene_time_us,
    output logic [47:0]      o_realtime_us,
    output logic [31:0]      o_smooth_delta_us,
    output logic [31:0]      o_frame_number,
    output logic [27:0]      o_fps_value,
    output logic             o_fps_updated
);

    localparam int PW   = (RING_DEPTH > 1) ? RING_LG : 1;
    localparam int RS_W = 32 + RING_LG;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RING     = 3'd1;
    localparam logic [2:0] S_FPS_MUL  = 3'd2;
    localparam logic [2:0] S_FPS_CHK  = 3'd3;
    localparam logic [2:0] S_FPS_WAIT = 3'd4;

    logic [2:0]            r_state;
    logic [31:0]           r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [31:0]           r_rd_data;
    logic                  r_rd_vld;
    logic [PW-1:0]         r_pos;
    logic [RS_W-1:0]       r_ring_sum;
    logic [47:0]           r_game;
    logic [47:0]           r_scene;
    logic [47:0]           r_real;
    logic [31:0]           r_frames;
    logic [23:0]           r_win_frames;
    logic [24:0]           r_win_elapsed;
    logic [27:0]           r_last_fps;
    logic [51:0]           r_fps_num;
    logic [31:0]           r_cur_scaled;
    logic [23:0]           r_out_unscaled;
    logic [31:0]           r_out_scaled;
    logic                  r_out_updated;
    logic                  r_out_valid;

    logic                  w_out_free;
    logic [23:0]           w_win;
    logic [31:0]           w_old;
    logic                  w_div_start;
    t_div_req              w_div_req;
    logic                  w_div_done;
    logic [DIV_Q_W-1:0]    w_div_quot;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty && w_out_free;
    assign w_win      = (i_fps_window_us == '0) ? 24'd1 : i_fps_window_us;
    assign w_old      = r_rd_vld ? r_rd_data : 32'd0;

    always_comb begin
        w_div_start = 1'b0;
        w_div_req   = '0;
        if (r_state == S_FPS_CHK) begin
            w_div_start       = (DIV_REM_W'(r_fps_num[51:28]) < r_win_elapsed);
            w_div_req.num_hi  = DIV_REM_W'(r_fps_num[51:32]);
            w_div_req.num_lo  = r_fps_num[31:0];
            w_div_req.divisor = r_win_elapsed;
        end
    end

    fts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ring storage: one registered read at the write position
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_ring[r_pos];
        if (r_state == S_RING) begin
            r_ring[r_pos] <= r_cur_scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ring_vld     <= '0;
            r_rd_vld       <= 1'b0;
            r_pos          <= '0;
            r_ring_sum     <= '0;
            r_game         <= '0;
            r_scene        <= '0;
            r_real         <= '0;
            r_frames       <= '0;
            r_win_frames   <= '0;
            r_win_elapsed  <= '0;
            r_last_fps     <= '0;
            r_fps_num      <= '0;
            r_cur_scaled   <= '0;
            r_out_unscaled <= '0;
            r_out_scaled   <= '0;
            r_out_updated  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_rd_vld <= r_ring_vld[r_pos];
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.is_tick) begin
                            r_real         <= r_real + 48'(i_cmd.raw);
                            r_game         <= r_game + 48'(i_cmd.scaled);
                            r_scene        <= r_scene + 48'(i_cmd.scaled);
                            r_frames       <= r_frames + 32'd1;
                            if (r_win_frames != CNT24_MAX) begin
                                r_win_frames <= r_win_frames + 24'd1;
                            end
                            r_win_elapsed  <= r_win_elapsed + 25'(i_cmd.clamped);
                            r_cur_scaled   <= i_cmd.scaled;
                            r_out_unscaled <= i_cmd.clamped;
                            r_out_scaled   <= i_cmd.scaled;
                            r_state        <= S_RING;
                        end else begin
                            // scene reset: answer at once with current state
                            r_scene        <= '0;
                            r_out_unscaled <= '0;
                            r_out_scaled   <= '0;
                            r_out_updated  <= 1'b0;
                            r_out_valid    <= 1'b1;
                        end
                    end
                end
                S_RING: begin
                    r_ring_sum        <= r_ring_sum - RS_W'(w_old) + RS_W'(r_cur_scaled);
                    r_ring_vld[r_pos] <= 1'b1;
                    r_pos <= (r_pos == PW'(RING_DEPTH-1)) ? '0 : r_pos + 1'b1;
                    if (r_win_elapsed >= 25'(w_win)) begin
                        r_state <= S_FPS_MUL;
                    end else begin
                        r_out_updated <= 1'b0;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_FPS_MUL: begin
                    r_fps_num <= 52'(r_win_frames) * 52'(FPS_SCALE);
                    r_state   <= S_FPS_CHK;
                end
                S_FPS_CHK: begin
                    // quotient of 2^28 or more saturates without dividing
                    if (!w_div_start) begin
                        r_last_fps    <= FPS_SAT;
                        r_win_frames  <= '0;
                        r_win_elapsed <= '0;
                        r_out_updated <= 1'b1;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        r_state <= S_FPS_WAIT;
                    end
                end
                S_FPS_WAIT: begin
                    if (w_div_done) begin
                        r_last_fps    <= w_div_quot[27:0];
                        r_win_frames  <= '0;
                        r_win_elapsed <= '0;
                        r_out_updated <= 1'b1;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // state stays still while a result waits, so it drives the outputs directly
    assign o_valid             = r_out_valid;
    assign o_unscaled_delta_us = r_out_unscaled;
    assign o_scaled_delta_us   = r_out_scaled;
    assign o_game_time_us      = r_game;
    assign o_scene_time_us     = r_scene;
    assign o_realtime_us       = r_real;
    // mean of the ring: drop the low bits of the sum
    assign o_smooth_delta_us   = r_ring_sum[RS_W-1:RING_LG];
    assign o_frame_number      = r_frames;
    assign o_fps_value         = r_last_fps;
    assign o_fps_updated       = r_out_updated;

endmodule
`default_nettype wire

// File: src/frame_time_statistics_unit.sv
// Top level of the frame time statistics unit: config registers, front, queue, back.
//
//  channel   direction  handshake                 word
//  input     in         i_valid / o_stall         i_opcode, i_raw_delta_us
//  result    out        o_valid / i_stall         o_unscaled_delta_us .. o_fps_updated
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A scene reset word is answered from the idle state, a plain tick after the ring state.
// A tick that closes an FPS window also passes the FPS multiply and check states and waits
// for the FPS value from the two-bit-per-cycle divider; when the quotient would pass 28
// bits it saturates without dividing and the word leaves from the check state. Reset is
// synchronous and active low, clears control state, loads config defaults; the two-entry queue
// keeps accepting words while a result is stalled at the output and stalls input when full.
`default_nettype none
module frame_time_statistics_unit
    import fts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_opcode,
    input  wire logic [23:0] i_raw_delta_us,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [23:0]      o_unscaled_delta_us,
    output logic [31:0]      o_scaled_delta_us,
    output logic [47:0]      o_game_time_us,
    output logic [47:0]      o_scene_time_us,
    output logic [47:0]      o_realtime_us,
    output logic [31:0]      o_smooth_delta_us,
    output logic [31:0]      o_frame_number,
    output logic [27:0]      o_fps_value,
    output logic             o_fps_updated,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    logic [23:0] r_max_delta;
    logic [15:0] r_time_scale;
    logic [23:0] r_fps_window;

    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_cmd        w_front_cmd;
    t_cmd        w_back_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delta  <= MAX_DELTA_RST;
            r_time_scale <= TIME_SCALE_RST;
            r_fps_window <= FPS_WINDOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_DELTA:  r_max_delta  <= i_cfg_data;
                CFG_TIME_SCALE: r_time_scale <= i_cfg_data[15:0];
                CFG_FPS_WINDOW: r_fps_window <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    fts_front u_front (
        .i_valid        (i_valid),
        .i_opcode       (i_opcode),
        .i_raw_delta_us (i_raw_delta_us),
        .i_max_delta_us (r_max_delta),
        .i_time_scale   (r_time_scale),
        .i_q_full       (w_full),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    fts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_back_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    fts_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (w_empty),
        .i_cmd               (w_back_cmd),
        .o_pop               (w_pop),
        .i_fps_window_us     (r_fps_window),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_unscaled_delta_us (o_unscaled_delta_us),
        .o_scaled_delta_us   (o_scaled_delta_us),
        .o_game_time_us      (o_game_time_us),
        .o_scene_time_us     (o_scene_time_us),
        .o_realtime_us       (o_realtime_us),
        .o_smooth_delta_us   (o_smooth_delta_us),
        .o_frame_number      (o_frame_number),
        .o_fps_value         (o_fps_value),
        .o_fps_updated       (o_fps_updated)
    );

endmodule
`default_nettype wire
